[rtl/heightmap_normal_generator_top_assert.svh]
// ----------------------------------------------------------------------------
// Heightmap normal generator assertion macros
// Shared concurrent assertion forms, clocked on the rising edge with reset.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_NORMAL_GENERATOR_TOP_ASSERT_SVH
`define HEIGHTMAP_NORMAL_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define HNG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HNG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/hng_pkg.sv]
// ----------------------------------------------------------------------------
// hng_pkg
// Shared widths, codes and the command and job structs of the normal generator.
// ----------------------------------------------------------------------------
package hng_pkg;

    localparam int SIDE_W    = 11;
    localparam int COL_OUT_W = 10;
    localparam int ROW_OUT_W = 10;
    localparam int NXY_W     = 16;
    localparam int NZ_W      = 15;
    localparam int FRAC_W    = 15;
    localparam int DIV_STEPS = 16;

    // input operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    // read slots of the line store
    localparam logic [1:0] SLOT_XLO = 2'd0;
    localparam logic [1:0] SLOT_XHI = 2'd1;
    localparam logic [1:0] SLOT_YLO = 2'd2;
    localparam logic [1:0] SLOT_YHI = 2'd3;

    // squaring steps
    localparam logic [1:0] SQ_A   = 2'd0;
    localparam logic [1:0] SQ_B   = 2'd1;
    localparam logic [1:0] SQ_ACC = 2'd2;

    // normal components for the divider
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    // one pixel's job, fixed at accept
    typedef struct packed {
        logic              drain;
        logic [SIDE_W-1:0] col;
        logic [SIDE_W-1:0] row;
        logic [SIDE_W-1:0] xlo_col;
        logic [SIDE_W-1:0] xhi_col;
        logic [SIDE_W-1:0] side;
        logic              x_bit;
        logic              ylo_bit;
        logic              yhi_bit;
        logic              wr_bit;
        logic              kx2;
        logic              ky2;
        logic              last;
    } job_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic [1:0] rd_slot;
        logic       wr_en;
        logic       diff;
        logic       mul;
        logic       sq_en;
        logic [1:0] sq_step;
        logic       root_step;
        logic       div_init;
        logic       div_step;
        logic       div_last;
        logic [1:0] div_sel;
        logic       out_load;
    } cmd_t;

endpackage

[rtl/hng_ctrl.sv]
// ----------------------------------------------------------------------------
// hng_ctrl
// Frame position counters, side register and the sequencing state machine.
// ----------------------------------------------------------------------------
module hng_ctrl #(
    parameter int MAX_SIDE   = 1024,
    parameter int ROOT_STEPS = 29
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       operation,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [hng_pkg::SIDE_W-1:0] side,
    output logic                       out_valid,
    input  logic                       out_ready,
    output hng_pkg::cmd_t              cmd,
    output hng_pkg::job_t              job
);

    localparam int SW       = hng_pkg::SIDE_W;
    localparam int SIDE_RST = (256 > MAX_SIDE) ? MAX_SIDE : 256;
    localparam int CNT_MAX  = (ROOT_STEPS > hng_pkg::DIV_STEPS + 1) ?
                              ROOT_STEPS : hng_pkg::DIV_STEPS + 1;
    localparam int CNT_W    = $clog2(CNT_MAX);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_READ  = 9'b000000010,
        S_WRITE = 9'b000000100,
        S_DIFF  = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_SQR   = 9'b000100000,
        S_ROOT  = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t          state_reg, state_next;
    logic [SW-1:0]   side_reg, side_next;
    logic [SW-1:0]   in_col_reg, in_col_next;
    logic [SW-1:0]   in_row_reg, in_row_next;
    logic [SW-1:0]   drain_col_reg, drain_col_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]      comp_reg, comp_next;
    logic            drain_reg, drain_next;
    logic            produce_reg, produce_next;
    logic            out_valid_reg, out_valid_next;

    logic            accept;
    logic [SW+1:0]   side_wide;
    logic [SW-1:0]   side_clamped;
    logic [SW-1:0]   c_cur;
    logic [SW-1:0]   last_col;
    logic [SW-1:0]   last_row;
    logic            out_free;

    // a config write goes ahead of a waiting input beat
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign last_col  = side_reg - SW'(1);
    assign last_row  = side_reg - SW'(1);

    // clamp written side into range
    always_comb
    begin
        side_wide = {2'b00, side};
        if (side_wide < (SW+2)'(2))
            side_clamped = SW'(2);
        else if (side_wide > (SW+2)'(MAX_SIDE))
            side_clamped = SW'(MAX_SIDE);
        else
            side_clamped = side;
    end

    // job and frame position for the item at the input
    always_comb
    begin
        job              = '0;
        job.side         = side_reg;
        produce_next     = produce_reg;
        drain_next       = drain_reg;
        in_col_next      = in_col_reg;
        in_row_next      = in_row_reg;
        drain_col_next   = drain_col_reg;
        side_next        = side_reg;
        c_cur            = (operation == hng_pkg::OP_DRAIN) ? drain_col_reg : in_col_reg;

        // x neighbours of column c_cur
        if (c_cur == '0)
        begin
            job.xlo_col = '0;
            job.xhi_col = SW'(1);
            job.kx2     = 1'b1;
        end
        else if (c_cur == last_col)
        begin
            job.xlo_col = c_cur - SW'(1);
            job.xhi_col = c_cur;
            job.kx2     = 1'b1;
        end
        else
        begin
            job.xlo_col = c_cur - SW'(1);
            job.xhi_col = c_cur + SW'(1);
            job.kx2     = 1'b0;
        end
        job.col = c_cur;

        if (operation == hng_pkg::OP_DRAIN)
        begin
            job.drain   = 1'b1;
            job.row     = last_row;
            job.x_bit   = last_row[0];
            job.ylo_bit = ~last_row[0];
            job.yhi_bit = last_row[0];
            job.wr_bit  = last_row[0];
            job.ky2     = 1'b1;
            job.last    = (c_cur == last_col);
        end
        else
        begin
            job.drain   = 1'b0;
            job.row     = in_row_reg - SW'(1);
            job.x_bit   = ~in_row_reg[0];
            job.ylo_bit = (in_row_reg == SW'(1)) ? 1'b0 : in_row_reg[0];
            job.yhi_bit = in_row_reg[0];
            job.wr_bit  = in_row_reg[0];
            job.ky2     = (in_row_reg == SW'(1));
            job.last    = 1'b0;
        end

        if (accept)
        begin
            drain_next   = (operation == hng_pkg::OP_DRAIN);
            produce_next = 1'b0;
            if (operation == hng_pkg::OP_DRAIN)
            begin
                if (in_row_reg == side_reg && drain_col_reg < side_reg)
                begin
                    produce_next   = 1'b1;
                    drain_col_next = drain_col_reg + SW'(1);
                    if (drain_col_next >= side_reg)
                    begin
                        drain_col_next = '0;
                        in_row_next    = '0;
                        in_col_next    = '0;
                    end
                end
            end
            else if (in_row_reg < side_reg && in_col_reg < side_reg)
            begin
                produce_next = (in_row_reg != '0);
                in_col_next  = in_col_reg + SW'(1);
                if (in_col_next >= side_reg)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + SW'(1);
                end
            end
        end

        if (cfg_valid && cfg_ready)
        begin
            side_next      = side_clamped;
            in_col_next    = '0;
            in_row_next    = '0;
            drain_col_next = '0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        comp_next      = comp_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.rd_slot    = cnt_reg[1:0];
        cmd.sq_step    = cnt_reg[1:0];
        cmd.div_sel    = comp_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (produce_next)
                        state_next = S_READ;
                    else if (operation == hng_pkg::OP_SAMPLE &&
                             in_row_reg < side_reg && in_col_reg < side_reg)
                        state_next = S_WRITE;
                end
            end
            S_READ:
            begin
                cmd.rd_en = 1'b1;
                if (cnt_reg[1:0] == (drain_reg ? hng_pkg::SLOT_YHI : hng_pkg::SLOT_YLO))
                    state_next = S_WRITE;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            S_WRITE:
            begin
                cmd.wr_en  = !drain_reg;
                state_next = produce_reg ? S_DIFF : S_IDLE;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = S_SQR;
            end
            S_SQR:
            begin
                cmd.sq_en = 1'b1;
                if (cnt_reg[1:0] == hng_pkg::SQ_ACC)
                begin
                    cnt_next   = '0;
                    state_next = S_ROOT;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    comp_next  = hng_pkg::COMP_X;
                    state_next = S_DIV;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            S_DIV:
            begin
                // step zero loads the operands, then one quotient bit per cycle
                cmd.div_init = (cnt_reg == '0);
                cmd.div_step = (cnt_reg != '0);
                cmd.div_last = (cnt_reg == CNT_W'(hng_pkg::DIV_STEPS));
                if (cnt_reg == CNT_W'(hng_pkg::DIV_STEPS))
                begin
                    cnt_next = '0;
                    if (comp_reg == hng_pkg::COMP_Z)
                        state_next = S_OUT;
                    else
                        comp_next = comp_reg + 2'd1;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            side_reg      <= SW'(SIDE_RST);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            drain_col_reg <= '0;
            cnt_reg       <= '0;
            comp_reg      <= hng_pkg::COMP_X;
            drain_reg     <= 1'b0;
            produce_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            side_reg      <= side_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            drain_col_reg <= drain_col_next;
            cnt_reg       <= cnt_next;
            comp_reg      <= comp_next;
            drain_reg     <= drain_next;
            produce_reg   <= produce_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/hng_datapath.sv]
// ----------------------------------------------------------------------------
// hng_datapath
// Line store, gradient multiply, bit-serial square root, shared restoring
// divider and the output register.
// ----------------------------------------------------------------------------
module hng_datapath #(
    parameter int MAX_SIDE    = 1024,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hng_pkg::cmd_t                 cmd,
    input  hng_pkg::job_t                 job,
    input  logic [HEIGHT_BITS-1:0]        height_sample,
    output logic signed [hng_pkg::NXY_W-1:0] normal_x,
    output logic signed [hng_pkg::NXY_W-1:0] normal_y,
    output logic [hng_pkg::NZ_W-1:0]      normal_z,
    output logic [hng_pkg::COL_OUT_W-1:0] pixel_col,
    output logic [hng_pkg::ROW_OUT_W-1:0] pixel_row,
    output logic                          frame_end
);

    localparam int EFF   = (HEIGHT_BITS > 16) ? 16 : HEIGHT_BITS;
    localparam int CW    = $clog2(MAX_SIDE);
    localparam int AW    = CW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int SW    = hng_pkg::SIDE_W;
    localparam int FW    = hng_pkg::FRAC_W;
    localparam int MAGW  = EFF + 1 + SW;
    localparam int QW    = 2 * MAGW + 2;
    localparam int RW    = MAGW + 1;
    localparam int NUMW  = MAGW + FW + 1;

    hng_pkg::job_t     job_reg;
    logic [EFF-1:0]    h_reg;
    logic [EFF-1:0]    mem [DEPTH];
    logic [EFF-1:0]    rdata_reg;
    logic              rd_en_prev_reg;
    logic [1:0]        rd_slot_prev_reg;
    logic [EFF-1:0]    slot_reg [4];
    logic [EFF:0]      dxm_reg, dym_reg;
    logic              xneg_reg, yneg_reg;
    logic [MAGW-1:0]   ma_reg, mb_reg;
    logic [2*MAGW-1:0] sq_reg;
    logic [QW-1:0]     v_reg, res_reg, bit_reg;
    logic [NUMW-1:0]   rem_reg, den_reg;
    logic [15:0]       q_reg;
    logic [15:0]       nx_reg, ny_reg;
    logic [FW-1:0]     nz_reg;
    logic [15:0]       out_x_reg, out_y_reg;
    logic [FW-1:0]     out_z_reg;
    logic [hng_pkg::COL_OUT_W-1:0] out_col_reg;
    logic [hng_pkg::ROW_OUT_W-1:0] out_row_reg;
    logic              out_last_reg;

    logic [AW-1:0]     raddr, waddr;
    logic [EFF-1:0]    xl, xh, yl, yh, dxa, dya;
    logic [MAGW-1:0]   sq_op;
    logic [2*MAGW-1:0] sq_ext;
    logic [QW-1:0]     root_t;
    logic              root_ge;
    logic [RW-1:0]     root;
    logic [MAGW-1:0]   div_m;
    logic              div_ge;
    logic [15:0]       q_fin;
    logic [FW-1:0]     q_sat;

    // line store addresses
    always_comb
    begin
        case (cmd.rd_slot)
            hng_pkg::SLOT_XLO: raddr = {job_reg.x_bit, CW'(job_reg.xlo_col)};
            hng_pkg::SLOT_XHI: raddr = {job_reg.x_bit, CW'(job_reg.xhi_col)};
            hng_pkg::SLOT_YLO: raddr = {job_reg.ylo_bit, CW'(job_reg.col)};
            default:           raddr = {job_reg.yhi_bit, CW'(job_reg.col)};
        endcase
    end
    assign waddr = {job_reg.wr_bit, CW'(job_reg.col)};

    // line store: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[waddr] <= h_reg;
        if (cmd.rd_en)
            rdata_reg <= mem[raddr];
    end

    // read bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_en_prev_reg   <= 1'b0;
            rd_slot_prev_reg <= hng_pkg::SLOT_XLO;
        end
        else
        begin
            rd_en_prev_reg   <= cmd.rd_en;
            rd_slot_prev_reg <= cmd.rd_slot;
        end
    end

    // neighbour values and absolute differences
    assign xl  = slot_reg[hng_pkg::SLOT_XLO];
    assign xh  = slot_reg[hng_pkg::SLOT_XHI];
    assign yl  = slot_reg[hng_pkg::SLOT_YLO];
    assign yh  = job_reg.drain ? slot_reg[hng_pkg::SLOT_YHI] : h_reg;
    assign dxa = (xl < xh) ? (xh - xl) : (xl - xh);
    assign dya = (yl < yh) ? (yh - yl) : (yl - yh);

    // squaring operand
    assign sq_op  = (cmd.sq_step == hng_pkg::SQ_A) ? ma_reg : mb_reg;
    assign sq_ext = {{MAGW{1'b0}}, sq_op};

    // square root step
    assign root_t  = res_reg + bit_reg;
    assign root_ge = (v_reg >= root_t);
    assign root    = res_reg[RW-1:0];

    // divider step
    always_comb
    begin
        case (cmd.div_sel)
            hng_pkg::COMP_X: div_m = ma_reg;
            hng_pkg::COMP_Y: div_m = mb_reg;
            default:         div_m = MAGW'(1) << (EFF + 1);
        endcase
    end
    assign div_ge = (rem_reg >= den_reg);
    assign q_fin  = {q_reg[14:0], div_ge};
    assign q_sat  = q_fin[15] ? {FW{1'b1}} : q_fin[FW-1:0];

    always_ff @(posedge clk)
    begin
        // job capture
        if (cmd.load)
        begin
            job_reg <= job;
            h_reg   <= height_sample[HEIGHT_BITS-1 -: EFF];
        end

        if (rd_en_prev_reg)
            slot_reg[rd_slot_prev_reg] <= rdata_reg;

        // gradient magnitudes, doubled for one-sided differences
        if (cmd.diff)
        begin
            dxm_reg  <= job_reg.kx2 ? {dxa, 1'b0} : {1'b0, dxa};
            dym_reg  <= job_reg.ky2 ? {dya, 1'b0} : {1'b0, dya};
            xneg_reg <= (xl < xh);
            yneg_reg <= (yl < yh);
        end

        if (cmd.mul)
        begin
            ma_reg <= {{(MAGW-EFF-1){1'b0}}, dxm_reg} * {{(MAGW-SW){1'b0}}, job_reg.side};
            mb_reg <= {{(MAGW-EFF-1){1'b0}}, dym_reg} * {{(MAGW-SW){1'b0}}, job_reg.side};
        end

        // sum of squares, then root setup
        if (cmd.sq_en)
        begin
            sq_reg <= sq_ext * sq_ext;
            case (cmd.sq_step)
                hng_pkg::SQ_B:
                begin
                    v_reg <= (QW'(1) << (2 * EFF + 2)) + QW'(sq_reg);
                end
                hng_pkg::SQ_ACC:
                begin
                    v_reg   <= v_reg + QW'(sq_reg);
                    res_reg <= '0;
                    bit_reg <= QW'(1) << (QW - 2);
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.root_step)
        begin
            if (root_ge)
            begin
                v_reg   <= v_reg - root_t;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end

        // rounded quotient m * 2^15 / R
        if (cmd.div_init)
        begin
            rem_reg <= NUMW'({div_m, {FW{1'b0}}}) + NUMW'(root >> 1);
            den_reg <= {root, {FW{1'b0}}};
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            if (div_ge)
                rem_reg <= rem_reg - den_reg;
            den_reg <= den_reg >> 1;
            q_reg   <= q_fin;
        end
        if (cmd.div_last)
        begin
            case (cmd.div_sel)
                hng_pkg::COMP_X: nx_reg <= xneg_reg ? 16'd0 - {1'b0, q_sat} : {1'b0, q_sat};
                hng_pkg::COMP_Y: ny_reg <= yneg_reg ? 16'd0 - {1'b0, q_sat} : {1'b0, q_sat};
                default:         nz_reg <= q_sat;
            endcase
        end

        // output register
        if (cmd.out_load)
        begin
            out_x_reg    <= nx_reg;
            out_y_reg    <= ny_reg;
            out_z_reg    <= nz_reg;
            out_col_reg  <= job_reg.col[hng_pkg::COL_OUT_W-1:0];
            out_row_reg  <= job_reg.row[hng_pkg::ROW_OUT_W-1:0];
            out_last_reg <= job_reg.last;
        end
    end

    assign normal_x  = out_x_reg;
    assign normal_y  = out_y_reg;
    assign normal_z  = out_z_reg;
    assign pixel_col = out_col_reg;
    assign pixel_row = out_row_reg;
    assign frame_end = out_last_reg;

endmodule

[rtl/heightmap_normal_generator_top.sv]
// ----------------------------------------------------------------------------
// heightmap_normal_generator_top
// Central-difference surface normals of a square heightmap, Q1.15 output.
// ----------------------------------------------------------------------------
// Input (in_valid/in_ready): operation 0 is one height sample in raster order,
// x fastest; operation 1 is a drain beat that emits one normal of the last row.
// The normal of pixel (c, r) comes out after sample (c, r+1); side drain beats
// flush the last row. Output (out_valid/out_ready): one normal per producing beat.
// Config (cfg_valid/cfg_ready, side): taken only while idle, ahead of a waiting
// input beat; it restarts the frame position.
// Timing: one beat at a time. A producing beat runs 3 or 4 line store reads,
// 3 squaring steps, EFF+13 root steps and 3 x 17 divider steps, with
// EFF = min(HEIGHT_BITS, 16). A sample of row 0 only writes the line store;
// a beat outside the frame and a drain with no result leave the block idle.
// Stall: the output register lets the next beat be taken while a result waits;
// the result after that holds in the sequencer and the input stalls.
// Reset: side returns to 256 and the frame position to zero; the line store is
// not cleared, every read hits an entry of the current frame.
// ----------------------------------------------------------------------------
`include "heightmap_normal_generator_top_assert.svh"

module heightmap_normal_generator_top #(
    parameter int MAX_SIDE    = 1024,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              operation,
    input  logic [HEIGHT_BITS-1:0]            height_sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [hng_pkg::NXY_W-1:0]  normal_x,
    output logic signed [hng_pkg::NXY_W-1:0]  normal_y,
    output logic [hng_pkg::NZ_W-1:0]          normal_z,
    output logic [hng_pkg::COL_OUT_W-1:0]     pixel_col,
    output logic [hng_pkg::ROW_OUT_W-1:0]     pixel_row,
    output logic                              frame_end,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hng_pkg::SIDE_W-1:0]        side
);

    localparam int EFF        = (HEIGHT_BITS > 16) ? 16 : HEIGHT_BITS;
    localparam int ROOT_STEPS = EFF + 1 + hng_pkg::SIDE_W + 1;

    hng_pkg::cmd_t cmd;
    hng_pkg::job_t job;

    hng_ctrl #(
        .MAX_SIDE   (MAX_SIDE),
        .ROOT_STEPS (ROOT_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .side      (side),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .job       (job)
    );

    hng_datapath #(
        .MAX_SIDE    (MAX_SIDE),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .job           (job),
        .height_sample (height_sample),
        .normal_x      (normal_x),
        .normal_y      (normal_y),
        .normal_z      (normal_z),
        .pixel_col     (pixel_col),
        .pixel_row     (pixel_row),
        .frame_end     (frame_end)
    );

    // checks
    `HNG_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid || out_ready, "result overwritten while pending")
    `HNG_ASSERT_NOW(a_load_on_beat, clk, rst_n, cmd.load, in_valid && in_ready, "job loaded without an input beat")
    `HNG_ASSERT_NOW(a_frame_corner, clk, rst_n, out_valid && frame_end, pixel_col == pixel_row, "frame end off the corner pixel")

endmodule

[test/hng_normal_checker.sv]
// ----------------------------------------------------------------------------
// Heightmap normal checker
// Watches the sample, normal and side channels, keeps its own copy of the
// line store and frame position, predicts each normal and compares it.
// ----------------------------------------------------------------------------
module hng_normal_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        operation,
    input  logic [15:0] height_sample,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] normal_x,
    input  logic [15:0] normal_y,
    input  logic [14:0] normal_z,
    input  logic [9:0]  pixel_col,
    input  logic [9:0]  pixel_row,
    input  logic        frame_end,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [10:0] side,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LEN = 1024;

    typedef struct packed {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [14:0] nz;
        logic [9:0]  col;
        logic [9:0]  row;
        logic        fe;
    } normal_t;

    normal_t     normals_due[$];
    logic [15:0] lines[0:2*LINE_LEN-1];
    int unsigned map_side;
    int unsigned col_at;
    int unsigned row_at;
    int unsigned drain_at;

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // |v| * 2^15 / r, rounded half up, saturated
    function automatic longint unsigned unit_mag(input longint unsigned m,
                                                 input longint unsigned r);
        longint unsigned q = ((m << 15) + r / 2) / r;
        return (q > 32767) ? 32767 : q;
    endfunction

    function automatic logic [15:0] unit_signed(input longint v, input longint unsigned r);
        longint unsigned m = (v < 0) ? longint'(-v) : longint'(v);
        logic [15:0] q = 16'(unit_mag(m, r));
        return (v < 0) ? -q : q;
    endfunction

    function automatic longint height_at(input int unsigned row, input int unsigned col);
        return longint'(lines[(row & 1) * LINE_LEN + (col % LINE_LEN)]);
    endfunction

    function automatic normal_t surface_normal(input longint xl, input longint xh,
                                               input longint kx, input longint yl,
                                               input longint yh, input longint ky,
                                               input int unsigned col,
                                               input int unsigned row,
                                               input logic fe);
        longint a = (xl - xh) * longint'(map_side) * kx;
        longint b = (yl - yh) * longint'(map_side) * ky;
        longint s = longint'(1) << 17;
        longint unsigned r = root_floor(a * a + b * b + s * s);
        normal_t n;
        n.nx  = unit_signed(a, r);
        n.ny  = unit_signed(b, r);
        n.nz  = 15'(unit_mag(s, r));
        n.col = 10'(col);
        n.row = 10'(row);
        n.fe  = fe;
        return n;
    endfunction

    // append one predicted normal at the tail
    task automatic add_due(input normal_t n);
        normals_due.insert(normals_due.size(), n);
    endtask

    // x gradient neighbours of one row; k = 2 at the edges
    task automatic x_pair(input int unsigned row, input int unsigned c,
                          output longint lo, output longint hi, output longint k);
        if (c == 0) begin
            lo = height_at(row, 0); hi = height_at(row, 1); k = 2;
        end else if (c == map_side - 1) begin
            lo = height_at(row, c - 1); hi = height_at(row, c); k = 2;
        end else begin
            lo = height_at(row, c - 1); hi = height_at(row, c + 1); k = 1;
        end
    endtask

    task automatic take_beat(input logic op, input logic [15:0] h);
        longint xl, xh, kx, yl, ky;
        int unsigned c, r;
        if (op == hng_pkg::OP_SAMPLE) begin
            c = col_at;
            r = row_at;
            if (r >= map_side || c >= map_side) return;
            if (r >= 1) begin
                x_pair(r - 1, c, xl, xh, kx);
                if (r == 1) begin
                    yl = height_at(0, c); ky = 2;
                end else begin
                    yl = height_at(r, c); ky = 1;
                end
                add_due(surface_normal(xl, xh, kx, yl, longint'(h), ky, c, r - 1, 1'b0));
            end
            lines[(r & 1) * LINE_LEN + c] = h;
            col_at = c + 1;
            if (col_at >= map_side) begin
                col_at = 0;
                row_at = r + 1;
            end
        end else begin
            r = map_side - 1;
            c = drain_at;
            if (row_at != map_side || c >= map_side) return;
            x_pair(r, c, xl, xh, kx);
            add_due(surface_normal(xl, xh, kx, height_at(r - 1, c),
                                   height_at(r, c), 2, c, r,
                                   c == map_side - 1));
            drain_at = c + 1;
            if (drain_at >= map_side) begin
                drain_at = 0;
                row_at   = 0;
                col_at   = 0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        normal_t want;
        normal_t got;
        if (!rst_n) begin
            map_side = 256;
            col_at   = 0;
            row_at   = 0;
            drain_at = 0;
            errors  <= 0;
            pending <= 0;
            normals_due.delete();
        end else begin
            // side write: clamp and restart the frame
            if (cfg_valid && cfg_ready) begin
                map_side = (side < 2) ? 2 : (side > LINE_LEN) ? LINE_LEN : side;
                col_at   = 0;
                row_at   = 0;
                drain_at = 0;
            end
            if (in_valid && in_ready) take_beat(operation, height_sample);
            // compare each normal beat against the oldest prediction
            if (out_valid && out_ready) begin
                got = {normal_x, normal_y, normal_z, pixel_col, pixel_row, frame_end};
                if (normals_due.size() == 0) begin
                    $display("%0t: unexpected normal beat %h", $time, got);
                    errors <= errors + 1;
                end else begin
                    want = normals_due.pop_front();
                    if (want !== got) begin
                        $display("%0t: mismatch expected x=%h y=%h z=%h col=%0d row=%0d fe=%b",
                                 $time, want.nx, want.ny, want.nz, want.col, want.row,
                                 want.fe);
                        $display("%0t:          actual   x=%h y=%h z=%h col=%0d row=%0d fe=%b",
                                 $time, got.nx, got.ny, got.nz, got.col, got.row, got.fe);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= normals_due.size();
        end
    end

endmodule

[test/heightmap_normal_generator_top_tb.sv]
// ----------------------------------------------------------------------------
// Heightmap normal generator testbench
// Directed edge cases, then random frames of random sizes under varying
// sender gaps and receiver stalls; a checker module predicts and compares.
// ----------------------------------------------------------------------------
module heightmap_normal_generator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS = 1950;
    localparam int SETTLE       = 200;
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_LEN     = 3000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        operation = hng_pkg::OP_SAMPLE;
    logic [15:0] height_sample = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [14:0] normal_z;
    logic [9:0]  pixel_col;
    logic [9:0]  pixel_row;
    logic        frame_end;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] side = 11'd256;
    int          errors;
    int          pending;

    int          tx_pct = 0;
    int          rx_pct = 0;
    logic        hold_req = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    int          quiet = 0;
    int          beats_sent = 0;

    always #1 clk = ~clk;

    heightmap_normal_generator_top uut (
        .clk, .rst_n, .in_valid, .in_ready, .operation, .height_sample,
        .out_valid, .out_ready, .normal_x, .normal_y, .normal_z,
        .pixel_col, .pixel_row, .frame_end, .cfg_valid, .cfg_ready, .side
    );

    hng_normal_checker chk (
        .clk, .rst_n, .in_valid, .in_ready, .operation, .height_sample,
        .out_valid, .out_ready, .normal_x, .normal_y, .normal_z,
        .pixel_col, .pixel_row, .frame_end, .cfg_valid, .cfg_ready, .side,
        .errors, .pending
    );

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= rx_pct);
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic put_beat(input logic op, input logic [15:0] h);
        while (tx_pct > 0 && $urandom_range(0, 99) < tx_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        height_sample <= h;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    // let the last accepted beat reach the checker's count before waiting on it
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_side(input logic [10:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        side      <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned eff;
        int unsigned style;
        int unsigned base;
        int          phase;
        logic [15:0] h;
        logic [10:0] v;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // smallest map: early drain, sample while drain pending, late drain
        write_side(11'd0);
        put_beat(hng_pkg::OP_DRAIN, 16'h0000);
        put_beat(hng_pkg::OP_SAMPLE, 16'h0000);
        put_beat(hng_pkg::OP_SAMPLE, 16'hffff);
        put_beat(hng_pkg::OP_SAMPLE, 16'hffff);
        put_beat(hng_pkg::OP_SAMPLE, 16'h0000);
        put_beat(hng_pkg::OP_SAMPLE, 16'h1234);
        put_beat(hng_pkg::OP_DRAIN, 16'hffff);
        put_beat(hng_pkg::OP_DRAIN, 16'h0000);
        put_beat(hng_pkg::OP_DRAIN, 16'h0000);

        // 3x3 with interior pixel and extreme steps, then a new frame begins
        write_side(11'd3);
        put_beat(hng_pkg::OP_SAMPLE, 16'hffff);
        put_beat(hng_pkg::OP_SAMPLE, 16'h0000);
        put_beat(hng_pkg::OP_SAMPLE, 16'hffff);
        put_beat(hng_pkg::OP_SAMPLE, 16'h0000);
        put_beat(hng_pkg::OP_SAMPLE, 16'h5555);
        put_beat(hng_pkg::OP_SAMPLE, 16'hffff);
        put_beat(hng_pkg::OP_SAMPLE, 16'haaaa);
        put_beat(hng_pkg::OP_SAMPLE, 16'hffff);
        put_beat(hng_pkg::OP_SAMPLE, 16'h0000);
        put_beat(hng_pkg::OP_DRAIN, 16'h0000);
        put_beat(hng_pkg::OP_DRAIN, 16'h0000);
        put_beat(hng_pkg::OP_DRAIN, 16'h0000);
        put_beat(hng_pkg::OP_SAMPLE, 16'h8000);

        // random frames
        beats_sent = 0;
        phase = 0;
        while (beats_sent < RANDOM_BEATS) begin
            case (phase % 4)
                0: begin tx_pct = 0;  rx_pct = 0;  end
                1: begin tx_pct = 47; rx_pct = 0;  end
                2: begin tx_pct = 0;  rx_pct = 47; end
                default: begin tx_pct = 26; rx_pct = 26; end
            endcase
            if (phase == 3)
                v = 11'h7ff;
            else if ($urandom_range(0, 9) == 0)
                v = 11'($urandom_range(0, 1));
            else if ($urandom_range(0, 7) == 0)
                v = 11'd16;
            else
                v = 11'($urandom_range(2, 9));
            write_side(v);
            eff = (v < 2) ? 2 : (v > 1024) ? 1024 : v;

            if (phase == 2) hold_req <= ~hold_req;
            style = $urandom_range(0, 2);
            base  = $urandom_range(0, 65535);

            if (eff == 1024) begin
                // largest map: first row and a little of the second only
                for (int i = 0; i < 1026; i++)
                    put_beat(hng_pkg::OP_SAMPLE, 16'($urandom_range(0, 65535)));
            end else begin
                for (int i = 0; i < eff * eff; i++) begin
                    if (phase == 5 && i == eff * eff / 2) wait_drained();
                    case (style)
                        0: h = 16'($urandom_range(0, 65535));
                        1: h = 16'(base + $urandom_range(0, 255) - 128);
                        default: h = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
                    endcase
                    // occasional stray beat
                    if ($urandom_range(0, 49) == 0)
                        put_beat(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
                    put_beat(hng_pkg::OP_SAMPLE, h);
                end
                for (int i = 0; i < eff; i++)
                    put_beat(hng_pkg::OP_DRAIN, 16'($urandom_range(0, 65535)));
            end
            phase++;
        end

        wait_drained();
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/hng_pkg.sv
rtl/hng_ctrl.sv
rtl/hng_datapath.sv
rtl/heightmap_normal_generator_top.sv
test/hng_normal_checker.sv
test/heightmap_normal_generator_top_tb.sv
